FILE: sv/btsp_pkg.sv
// ----------------------------------------------------------------------------
// btsp_pkg
// shared types and constants for the bottleneck tour two-max bound block
// ----------------------------------------------------------------------------
package btsp_pkg;

    localparam int MAX_CITIES = 256;
    localparam int COST_BITS  = 32;
    localparam int IDX_BITS   = $clog2(MAX_CITIES);
    localparam int SIZE_BITS  = IDX_BITS + 1;

    // stream payload widths
    localparam int S_TDATA_BITS = ((COST_BITS + 2 * IDX_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((COST_BITS + 7) / 8) * 8;

    typedef logic signed [COST_BITS-1:0] t_cost;
    typedef logic        [IDX_BITS-1:0]  t_idx;
    typedef logic        [SIZE_BITS-1:0] t_size;

    localparam t_cost COST_MAX = {1'b0, {(COST_BITS-1){1'b1}}};
    localparam t_cost COST_MIN = {1'b1, {(COST_BITS-1){1'b0}}};

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_SYM_MODE    = 1'b0,
        CFG_MATRIX_SIZE = 1'b1
    } t_cfg_idx;

    localparam int CFG_DATA_BITS = SIZE_BITS;

    typedef struct packed {
        t_cost cost;
        t_idx  row;
        t_idx  col;
    } t_item;

    // column store write request
    typedef struct packed {
        logic  en;
        t_idx  addr;
        t_cost data;
    } t_col_wr;

    // step status from the bound core
    typedef struct packed {
        logic emit;
        logic in_range;
    } t_step_stat;

endpackage

FILE: sv/btsp_colmem.sv
// ----------------------------------------------------------------------------
// btsp_colmem
// column minimum store, one write and one registered read port
// ----------------------------------------------------------------------------
module btsp_colmem (
    input  logic             i_clk,
    input  btsp_pkg::t_col_wr i_wr,
    input  logic             i_rd_en,
    input  btsp_pkg::t_idx   i_rd_addr,
    output btsp_pkg::t_cost  o_rd_data
);
    import btsp_pkg::*;

    t_cost r_mem [MAX_CITIES];
    t_cost r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/btsp_core.sv
// ----------------------------------------------------------------------------
// btsp_core
// row tracking, column store update and running maximum for one item
// ----------------------------------------------------------------------------
module btsp_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_sym_mode,
    input  btsp_pkg::t_size     i_matrix_size,
    input  btsp_pkg::t_item     i_item,
    input  logic                i_valid,
    input  logic                i_go,
    input  btsp_pkg::t_cost     i_col_min,
    output btsp_pkg::t_step_stat o_stat,
    output btsp_pkg::t_col_wr   o_col_wr,
    output btsp_pkg::t_cost     o_bound
);
    import btsp_pkg::*;

    t_cost r_row_min, n_row_min;
    t_cost r_row_second, n_row_second;
    t_cost r_run_max, n_run_max;

    t_size n_eff;
    t_idx  last_idx;
    logic  in_range;
    logic  row_end;
    logic  last_row;
    t_cost col_val;
    t_cost fold_a;
    t_cost fold_b;
    t_cost max_a;
    t_cost max_ab;

    // clamp size to 1 .. MAX_CITIES
    always_comb begin
        if (i_matrix_size == '0) begin
            n_eff = t_size'(1);
        end else if (i_matrix_size > t_size'(MAX_CITIES)) begin
            n_eff = t_size'(MAX_CITIES);
        end else begin
            n_eff = i_matrix_size;
        end
    end

    assign last_idx = t_idx'(n_eff - t_size'(1));
    assign in_range = ({1'b0, i_item.row} < n_eff) && ({1'b0, i_item.col} < n_eff);
    assign row_end  = (i_item.col == last_idx);
    assign last_row = (i_item.row == last_idx);

    always_comb begin
        n_row_min    = r_row_min;
        n_row_second = r_row_second;
        col_val      = i_item.cost;
        fold_a       = COST_MIN;
        fold_b       = COST_MIN;

        if (i_sym_mode) begin
            if (i_item.cost < r_row_min) begin
                n_row_second = r_row_min;
                n_row_min    = i_item.cost;
            end else if (i_item.cost < r_row_second) begin
                n_row_second = i_item.cost;
            end
            if (row_end) begin
                fold_a = n_row_second;
            end
        end else begin
            if (i_item.cost < r_row_min) begin
                n_row_min = i_item.cost;
            end
            if (i_item.row != '0 && i_col_min < i_item.cost) begin
                col_val = i_col_min;
            end
            if (last_row) begin
                fold_a = col_val;
            end
            if (row_end) begin
                fold_b = n_row_min;
            end
        end

        if (row_end) begin
            n_row_min    = COST_MAX;
            n_row_second = COST_MAX;
        end
    end

    assign max_a  = (fold_a > r_run_max) ? fold_a : r_run_max;
    assign max_ab = (fold_b > max_a) ? fold_b : max_a;

    always_comb begin
        n_run_max = max_ab;
        if (row_end && last_row) begin
            n_run_max = COST_MIN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_min    <= COST_MAX;
            r_row_second <= COST_MAX;
            r_run_max    <= COST_MIN;
        end else if (i_go && in_range) begin
            r_row_min    <= n_row_min;
            r_row_second <= n_row_second;
            r_run_max    <= n_run_max;
        end
    end

    assign o_stat.emit     = i_valid && in_range && row_end && last_row;
    assign o_stat.in_range = in_range;
    assign o_col_wr.en     = i_go && in_range && !i_sym_mode;
    assign o_col_wr.addr   = i_item.col;
    assign o_col_wr.data   = col_val;
    assign o_bound         = max_ab;

endmodule

FILE: sv/bottleneck_tsp_two_max_bound.sv
// ----------------------------------------------------------------------------
// bottleneck_tsp_two_max_bound
// lower bound on the bottleneck tour from a row-major cost matrix stream
// ----------------------------------------------------------------------------
// result path: after the edge that accepts the last matrix element, the bound
//   passes the input register, then the result register, to o_m_axis_tvalid
// throughput: one item per cycle unless a result stalls; set by the single
//   compare and fold stage and column store read-modify-write, read at accept
// reset: synchronous, active low; clears stages, row registers, running maximum,
//   presets config; the column store is not cleared, row 0 writes it first
module bottleneck_tsp_two_max_bound (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input items
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [31:0] cost, [39:32] row_index, [47:40] col_index
    input  logic [btsp_pkg::S_TDATA_BITS-1:0]  i_s_axis_tdata,
    // result items
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [31:0] bound
    output logic [btsp_pkg::M_TDATA_BITS-1:0]  o_m_axis_tdata,
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_idx,
    input  logic [btsp_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import btsp_pkg::*;

    // configuration registers
    logic  r_sym_mode;
    t_size r_matrix_size;

    // input register stage
    logic  r_s1_valid;
    t_item r_s1_item;
    t_item in_item;
    logic  s_accept;
    logic  s1_go;

    // column store read with forwarding of the write made at accept
    t_cost   mem_rd_data;
    logic    r_fwd;
    t_cost   r_fwd_data;
    t_cost   col_min;
    t_col_wr col_wr;

    // result register
    logic       r_out_valid;
    t_cost      r_out_bound;
    t_step_stat stat;
    t_cost      bound;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_mode    <= 1'b1;
            r_matrix_size <= t_size'(MAX_CITIES);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SYM_MODE:    r_sym_mode    <= i_cfg_data[0];
                CFG_MATRIX_SIZE: r_matrix_size <= i_cfg_data;
                default:         r_sym_mode    <= r_sym_mode;
            endcase
        end
    end

    // unpack the stream payload, cost in the low bits
    assign in_item.cost = i_s_axis_tdata[COST_BITS-1:0];
    assign in_item.row  = i_s_axis_tdata[COST_BITS +: IDX_BITS];
    assign in_item.col  = i_s_axis_tdata[COST_BITS+IDX_BITS +: IDX_BITS];

    // stage advances unless it has a bound to hand over and the result is stuck
    assign s1_go           = r_s1_valid && (!stat.emit || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || s1_go;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_item  <= in_item;
            // the item leaving now writes the column the new one reads
            r_fwd      <= col_wr.en && (col_wr.addr == in_item.col);
            r_fwd_data <= col_wr.data;
        end
    end

    btsp_colmem u_colmem (
        .i_clk     (i_clk),
        .i_wr      (col_wr),
        .i_rd_en   (s_accept),
        .i_rd_addr (in_item.col),
        .o_rd_data (mem_rd_data)
    );

    assign col_min = r_fwd ? r_fwd_data : mem_rd_data;

    btsp_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sym_mode    (r_sym_mode),
        .i_matrix_size (r_matrix_size),
        .i_item        (r_s1_item),
        .i_valid       (r_s1_valid),
        .i_go          (s1_go),
        .i_col_min     (col_min),
        .o_stat        (stat),
        .o_col_wr      (col_wr),
        .o_bound       (bound)
    );

    // result register, loaded on the last matrix element
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && stat.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && stat.emit) begin
            r_out_bound <= bound;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = M_TDATA_BITS'(unsigned'(r_out_bound));

endmodule

FILE: sv/btsp_checker.sv
// ----------------------------------------------------------------------------
// btsp_checker
// port-level checks for the bottleneck tour bound block
// ----------------------------------------------------------------------------
module btsp_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    input  logic                               o_s_axis_tready,
    input  logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    input  logic [btsp_pkg::M_TDATA_BITS-1:0]  o_m_axis_tdata
);

    logic s_accept;
    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;

    // no result is shown right after reset
    a_out_clear_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // a new result only comes from an item that passed the input register first
    a_out_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(s_accept, 2))
        else $error("result without a matching item");

    // with no pending result the input side never stalls
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input stalled with empty result register");

endmodule

bind bottleneck_tsp_two_max_bound btsp_checker u_btsp_checker (.*);
